[rtl/gmwg_pkg.sv]
// Shared types, constants and the quarter-wave sine table builder for the
// gated waveform generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gmwg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;
    localparam int COUNT_W         = 16;
    localparam int SAMPLE_W        = 16;
    localparam int AMP_W           = 15;
    localparam int STEP_W          = 32;
    localparam int MAG_W           = 17;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int IN_TDATA_W      = 8;

    localparam logic [MAG_W-1:0]   UNIT_Q16    = MAG_W'(65536);
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic [COUNT_W-1:0] GATE_RESET  = COUNT_W'(800);
    localparam logic [COUNT_W-1:0] TONE_RESET  = COUNT_W'(800);

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SAW      = 2'd1,
        SHAPE_SQUARE   = 2'd2,
        SHAPE_TRIANGLE = 2'd3
    } shape_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAPE = 3'd0,
        CFG_AMP   = 3'd1,
        CFG_STEP  = 3'd2,
        CFG_GATE  = 3'd3,
        CFG_TONE  = 3'd4
    } cfg_idx_e_t;

    typedef struct packed {
        shape_e_t            shape;
        logic [AMP_W-1:0]    amp;
        logic [STEP_W-1:0]   step;
        logic [COUNT_W-1:0]  gate;
        logic [COUNT_W-1:0]  tone;
    } cfg_t;

    // per-sample flags derived from the sample count
    typedef struct packed {
        logic gate_open;
        logic last;
    } tone_flags_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        tone_flags_t           flags;
    } phase_word_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             use_rom;
        tone_flags_t      flags;
    } wave_word_t;

    typedef logic [MAG_W-1:0] sine_rom_t [0:SINE_N];

    // sin(pi/2 * k / N) in Q16, seven-term Taylor series in Q30, rounded half up
    function automatic logic [MAG_W-1:0] sine_entry(input logic [SINE_TABLE_BITS:0] k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic signed [63:0] r;
        x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        acc  = $signed(x);
        term = ((x * x2) >> 30) / 6;
        acc  = acc - $signed(term);
        term = ((term * x2) >> 30) / 20;
        acc  = acc + $signed(term);
        term = ((term * x2) >> 30) / 42;
        acc  = acc - $signed(term);
        term = ((term * x2) >> 30) / 72;
        acc  = acc + $signed(term);
        term = ((term * x2) >> 30) / 110;
        acc  = acc - $signed(term);
        term = ((term * x2) >> 30) / 156;
        acc  = acc + $signed(term);
        if (acc < 0)
        begin
            acc = 0;
        end
        r = (acc + 64'sd8192) >>> 14;
        if (r > 64'sd65536)
        begin
            r = 64'sd65536;
        end
        return r[MAG_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k <= SINE_N; k++)
        begin
            rom[k] = sine_entry((SINE_TABLE_BITS+1)'(k));
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

[rtl/gmwg_phase.sv]
// Front stage: phase accumulator, saturating sample count and the input
// register. Depends on gmwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmwg_phase (
    input  wire                   clk,
    input  wire                   rst_n,
    input  gmwg_pkg::cfg_t        cfg,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire                   restart,
    output logic                  out_valid,
    input  wire                   out_free,
    output gmwg_pkg::phase_word_t out_word
);
    import gmwg_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [COUNT_W-1:0]    count_cur;
    logic                  valid_reg;
    phase_word_t           word_reg;
    phase_word_t           word_next;
    logic                  accept;

    assign in_ready  = !valid_reg || out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // restart clears phase and count before this sample is formed
    assign phase_cur = restart ? '0 : phase_reg;
    assign count_cur = restart ? '0 : count_reg;

    always_comb
    begin
        phase_next = phase_cur + PHASE_BITS'(cfg.step);
        count_next = (count_cur == '1) ? count_cur : count_cur + COUNT_W'(1);
        word_next.phase           = phase_cur;
        word_next.flags.gate_open = (count_cur < cfg.gate);
        word_next.flags.last      = (cfg.tone != '0) && (count_cur == cfg.tone - COUNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

[rtl/gmwg_wave.sv]
// Wave stage: quarter-wave sine ROM read and sawtooth, square, triangle
// shaping from the phase word. Depends on gmwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmwg_wave (
    input  wire                             clk,
    input  wire                             rst_n,
    input  gmwg_pkg::cfg_t                  cfg,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  gmwg_pkg::phase_word_t           in_word,
    output logic                            out_valid,
    input  wire                             out_free,
    output gmwg_pkg::wave_word_t            out_word,
    output logic [gmwg_pkg::MAG_W-1:0]      rom_data
);
    import gmwg_pkg::*;

    localparam sine_rom_t SineRom = build_sine_rom();

    logic                         valid_reg;
    wave_word_t                   word_reg;
    wave_word_t                   word_next;
    logic [MAG_W-1:0]             rom_data_reg;
    logic                         load;
    logic [1:0]                   quad;
    logic [SINE_TABLE_BITS-1:0]   idx;
    logic [SINE_TABLE_BITS:0]     rom_idx;
    logic [SAMPLE_W-1:0]          u;
    logic [MAG_W-1:0]             saw_abs;
    logic [MAG_W+1:0]             tri_val;

    assign in_ready  = !valid_reg || out_free;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign rom_data  = rom_data_reg;

    assign quad    = in_word.phase[PHASE_BITS-1 -: 2];
    assign idx     = in_word.phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    // odd quadrants read the table backward
    assign rom_idx = quad[0] ? (SINE_TABLE_BITS+1)'(SINE_N) - {1'b0, idx} : {1'b0, idx};
    assign u       = in_word.phase[PHASE_BITS-1 -: SAMPLE_W];
    assign saw_abs = u[SAMPLE_W-1] ? MAG_W'(UNIT_Q16 - {1'b0, u}) : {1'b0, u};
    assign tri_val = {saw_abs, 2'b00};

    always_comb
    begin
        word_next.flags   = in_word.flags;
        word_next.use_rom = 1'b0;
        word_next.mag     = '0;
        word_next.neg     = 1'b0;
        case (cfg.shape)
            SHAPE_SINE:
            begin
                word_next.use_rom = 1'b1;
                word_next.neg     = quad[1];
            end
            SHAPE_SAW:
            begin
                word_next.mag = saw_abs;
                word_next.neg = u[SAMPLE_W-1];
            end
            SHAPE_SQUARE:
            begin
                word_next.mag = UNIT_Q16;
                word_next.neg = !((in_word.phase != '0) && !in_word.phase[PHASE_BITS-1]);
            end
            default:
            begin
                // triangle: 4*|saw| - 1
                if (tri_val >= (MAG_W+2)'(UNIT_Q16))
                begin
                    word_next.mag = MAG_W'(tri_val - (MAG_W+2)'(UNIT_Q16));
                    word_next.neg = 1'b0;
                end
                else
                begin
                    word_next.mag = MAG_W'((MAG_W+2)'(UNIT_Q16) - tri_val);
                    word_next.neg = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg     <= word_next;
            rom_data_reg <= SineRom[rom_idx];
        end
    end

endmodule

`default_nettype wire

[rtl/gmwg_scale.sv]
// Output stage: amplitude multiply, truncation toward zero, gating and the
// output register. Depends on gmwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmwg_scale (
    input  wire                             clk,
    input  wire                             rst_n,
    input  gmwg_pkg::cfg_t                  cfg,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  gmwg_pkg::wave_word_t            in_word,
    input  wire [gmwg_pkg::MAG_W-1:0]       rom_data,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [gmwg_pkg::SAMPLE_W-1:0]   sample,
    output logic                            last_in_tone
);
    import gmwg_pkg::*;

    logic                        valid_reg;
    logic [SAMPLE_W-1:0]         sample_reg;
    logic [SAMPLE_W-1:0]         sample_next;
    logic                        last_reg;
    logic                        load;
    logic [MAG_W-1:0]            mag;
    logic [AMP_W+MAG_W-1:0]      prod;
    logic [SAMPLE_W-1:0]         scaled;

    assign in_ready     = !valid_reg || out_ready;
    assign load         = in_valid && in_ready;
    assign out_valid    = valid_reg;
    assign sample       = sample_reg;
    assign last_in_tone = last_reg;

    assign mag    = in_word.use_rom ? rom_data : in_word.mag;
    assign prod   = (AMP_W+MAG_W)'(cfg.amp) * (AMP_W+MAG_W)'(mag);
    // drop 16 fraction bits, magnitude stays below 2^15
    assign scaled = prod[SAMPLE_W +: SAMPLE_W];

    always_comb
    begin
        if (!in_word.flags.gate_open)
        begin
            sample_next = '0;
        end
        else if (in_word.neg)
        begin
            sample_next = SAMPLE_W'(-scaled);
        end
        else
        begin
            sample_next = scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_next;
            last_reg   <= in_word.flags.last;
        end
    end

endmodule

`default_nettype wire

[rtl/gated_multi_waveform_generator_core.sv]
// Top level of the gated waveform generator: configuration registers and
// the three-stage sample pipeline. Depends on gmwg_pkg, gmwg_phase,
// gmwg_wave and gmwg_scale.
//
//  Channel   Dir  Words                       Fields (low bit up)
//  s_axis    in   one per requested sample    tdata: restart, 7 zero bits
//  m_axis    out  one per accepted input      tdata: sample; tlast: last_in_tone
//  cfg       in   register write              cfg_index, cfg_data
//
// One sample per clock sustained while m_axis_tready is high; a word taken on
// s_axis passes the phase register, ROM/shape register and output register.
// Each stage holds its word while the next is full, so a stall on m_axis
// closes bubbles first and only then drops s_axis_tready. Reset clears phase,
// count, valid flags and configuration to their defaults; the sine table is a
// constant ROM and needs no fill. cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module gated_multi_waveform_generator_core (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire [gmwg_pkg::IN_TDATA_W-1:0]         s_axis_tdata,  // [0] restart
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    output logic [gmwg_pkg::SAMPLE_W-1:0]          m_axis_tdata,  // [15:0] sample
    output logic                                   m_axis_tlast,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire [gmwg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire [gmwg_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import gmwg_pkg::*;

    cfg_t          cfg_reg;
    phase_word_t   a_word;
    logic          a_valid;
    logic          b_ready;
    wave_word_t    b_word;
    logic          b_valid;
    logic          c_ready;
    logic [MAG_W-1:0] rom_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shape <= SHAPE_SINE;
            cfg_reg.amp   <= '0;
            cfg_reg.step  <= '0;
            cfg_reg.gate  <= GATE_RESET;
            cfg_reg.tone  <= TONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_e_t'(cfg_index))
                CFG_SHAPE: cfg_reg.shape <= shape_e_t'(cfg_data[1:0]);
                CFG_AMP:   cfg_reg.amp   <= cfg_data[AMP_W-1:0];
                CFG_STEP:  cfg_reg.step  <= cfg_data[STEP_W-1:0];
                CFG_GATE:  cfg_reg.gate  <= cfg_data[COUNT_W-1:0];
                CFG_TONE:  cfg_reg.tone  <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    gmwg_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .restart   (s_axis_tdata[0]),
        .out_valid (a_valid),
        .out_free  (b_ready),
        .out_word  (a_word)
    );

    gmwg_wave u_wave (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (a_valid),
        .in_ready  (b_ready),
        .in_word   (a_word),
        .out_valid (b_valid),
        .out_free  (c_ready),
        .out_word  (b_word),
        .rom_data  (rom_data)
    );

    gmwg_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (b_valid),
        .in_ready     (c_ready),
        .in_word      (b_word),
        .rom_data     (rom_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .sample       (m_axis_tdata),
        .last_in_tone (m_axis_tlast)
    );

endmodule

`default_nettype wire

[rtl/gmwg_checker.sv]
// Port-level checks for the gated waveform generator, bound to the top
// level. Depends on gmwg_pkg and gated_multi_waveform_generator_core.
`timescale 1ns / 1ps
`default_nettype none

module gmwg_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [gmwg_pkg::SAMPLE_W-1:0]     m_axis_tdata,
    input wire                              m_axis_tlast
);
    import gmwg_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // scaled magnitude never reaches full scale
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != {1'b1, {(SAMPLE_W-1){1'b0}}})
        else $error("sample hit negative full scale");

    // with no word waiting at the output the pipeline can always drain
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind gated_multi_waveform_generator_core gmwg_checker u_gmwg_checker (.*);

`default_nettype wire
